### rtl/multi_channel_edge_debouncer_assert.svh
// Assertion macros for the edge debouncer checker.
// Each expects clk and rst in scope.
`ifndef MULTI_CHANNEL_EDGE_DEBOUNCER_ASSERT_SVH
`define MULTI_CHANNEL_EDGE_DEBOUNCER_ASSERT_SVH

`define MCED_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

`define MCED_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/mced_pkg.sv
package mced_pkg;

  localparam int PIN_W     = 8;
  localparam int TICKS_W   = 16;
  localparam int CFG_IDX_W = 4;

  localparam logic [TICKS_W-1:0] TICKS_RESET  = 16'd50;
  localparam logic [PIN_W-1:0]   INVERT_RESET = 8'h00;
  localparam logic [PIN_W-1:0]   ENABLE_RESET = 8'hff;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DEBOUNCE_TICKS = 4'd0,
    REG_INVERT_MASK    = 4'd1,
    REG_CHANNEL_ENABLE = 4'd2
  } cfg_reg_t;

endpackage

### rtl/multi_channel_edge_debouncer.sv
// channel  signals                         payload
// -------  ------------------------------  ------------------------------------------
// tick in  in_valid / in_ready             raw_levels
// result   out_valid / out_ready           rising_flags, falling_flags, stable_levels
// config   cfg_valid / cfg_ready           cfg_index, cfg_data
//
// One tick per cycle while results drain: a tick is accepted, all channel countdowns update
// in parallel, and its result sits in the output register on the next cycle.
// A new tick is accepted while the output register is empty or being drained.
// A stalled result holds the input off; config writes are taken every cycle.
// Synchronous reset restores register defaults and arms the first-tick load.
module multi_channel_edge_debouncer
  import mced_pkg::*;
#(
  parameter int CHANNELS    = 8,
  parameter int COUNT_WIDTH = 16
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [PIN_W-1:0]     raw_levels,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [PIN_W-1:0]     rising_flags,
  output logic [PIN_W-1:0]     falling_flags,
  output logic [PIN_W-1:0]     stable_levels,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [TICKS_W-1:0]   cfg_data
);

  localparam int LANES = (CHANNELS < PIN_W) ? CHANNELS : PIN_W;

  logic [TICKS_W-1:0]     debounce_ticks;
  logic [PIN_W-1:0]       invert_mask;
  logic [PIN_W-1:0]       channel_enable;

  logic [PIN_W-1:0]       previous_raw;
  logic [PIN_W-1:0]       stable_level;
  logic [COUNT_WIDTH-1:0] countdown [LANES];
  logic                   first_tick_pending;

  logic [PIN_W-1:0]       stable_level_next;
  logic [COUNT_WIDTH-1:0] countdown_next [LANES];
  logic [PIN_W-1:0]       rise;
  logic [PIN_W-1:0]       fall;
  logic [COUNT_WIDTH-1:0] load;
  logic [COUNT_WIDTH-1:0] dec;
  logic                   now_level;
  logic                   accept;

  assign cfg_ready = 1'b1;
  assign in_ready  = !out_valid || out_ready;
  assign accept    = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      debounce_ticks <= TICKS_RESET;
      invert_mask    <= INVERT_RESET;
      channel_enable <= ENABLE_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_DEBOUNCE_TICKS: debounce_ticks <= cfg_data;
        REG_INVERT_MASK:    invert_mask    <= cfg_data[PIN_W-1:0];
        REG_CHANNEL_ENABLE: channel_enable <= cfg_data[PIN_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    load = COUNT_WIDTH'(debounce_ticks);
    if (load == '0) begin
      load = COUNT_WIDTH'(1);
    end
  end

  always_comb begin
    stable_level_next = stable_level;
    rise              = '0;
    fall              = '0;
    dec               = '0;
    now_level         = 1'b0;
    for (int i = 0; i < LANES; i++) begin
      countdown_next[i] = countdown[i];
    end
    if (first_tick_pending) begin
      stable_level_next = (raw_levels ^ invert_mask) & channel_enable;
    end else begin
      for (int i = 0; i < LANES; i++) begin
        dec       = countdown[i] - COUNT_WIDTH'(1);
        now_level = raw_levels[i] ^ invert_mask[i];
        if (!channel_enable[i]) begin
          countdown_next[i]    = '0;
          stable_level_next[i] = 1'b0;
        end else if (raw_levels[i] != previous_raw[i]) begin
          countdown_next[i] = load;
        end else if (countdown[i] != '0) begin
          countdown_next[i] = dec;
          if (dec == '0) begin
            rise[i]              = now_level && !stable_level[i];
            fall[i]              = !now_level && stable_level[i];
            stable_level_next[i] = now_level;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      previous_raw       <= '0;
      stable_level       <= '0;
      first_tick_pending <= 1'b1;
      for (int i = 0; i < LANES; i++) begin
        countdown[i] <= '0;
      end
    end else if (accept) begin
      previous_raw       <= raw_levels;
      stable_level       <= stable_level_next;
      first_tick_pending <= 1'b0;
      for (int i = 0; i < LANES; i++) begin
        countdown[i] <= countdown_next[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      rising_flags  <= rise;
      falling_flags <= fall;
      stable_levels <= stable_level_next;
    end
  end

endmodule

### rtl/mced_checker.sv
`include "multi_channel_edge_debouncer_assert.svh"

module mced_checker
  import mced_pkg::*;
(
  input logic             clk,
  input logic             rst,
  input logic             in_valid,
  input logic             in_ready,
  input logic             out_valid,
  input logic             out_ready,
  input logic [PIN_W-1:0] rising_flags,
  input logic [PIN_W-1:0] falling_flags,
  input logic [PIN_W-1:0] stable_levels
);

  `MCED_ASSERT_NEXT(a_result_holds, out_valid && !out_ready, out_valid && $stable(stable_levels) && $stable(rising_flags) && $stable(falling_flags), "stalled result changed")
  `MCED_ASSERT_NEXT(a_request_yields_result, in_valid && in_ready, out_valid, "accepted request gave no result")
  `MCED_ASSERT_NOW(a_flags_exclusive, out_valid, (rising_flags & falling_flags) == '0, "rising and falling on one channel")
  `MCED_ASSERT_NOW(a_rise_is_high, out_valid, (rising_flags & ~stable_levels) == '0, "rising flag with low stable level")
  `MCED_ASSERT_NOW(a_fall_is_low, out_valid, (falling_flags & stable_levels) == '0, "falling flag with high stable level")

endmodule

bind multi_channel_edge_debouncer mced_checker u_mced_checker (
  .clk           (clk),
  .rst           (rst),
  .in_valid      (in_valid),
  .in_ready      (in_ready),
  .out_valid     (out_valid),
  .out_ready     (out_ready),
  .rising_flags  (rising_flags),
  .falling_flags (falling_flags),
  .stable_levels (stable_levels)
);
